### sv/bdq_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and ring index helpers for the bounded deque
// no dependencies

package bdq_pkg;

  // ring store geometry
  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // fixed result field widths
  localparam int POS_FIELD_W = 4;
  localparam int CNT_FIELD_W = 5;
  localparam int VALUE_W     = 32;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  // operation codes on the input channel
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_MISS  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_PUSH_F,
    K_PUSH_B,
    K_POP_F,
    K_POP_B,
    K_SEARCH,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef struct packed {
    logic [2:0]                op;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [POS_FIELD_W-1:0]    found_position;
    logic [CNT_FIELD_W-1:0]    entry_count;
    logic                      is_empty;
  } out_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_ch_t;

  // (ptr + off) mod DEPTH, off below DEPTH
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // (ptr - 1) mod DEPTH
  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == '0) begin
      res = PTR_W'(DEPTH - 1);
    end else begin
      res = ptr - PTR_W'(1);
    end
    return res;
  endfunction

  // masked to the result field widths
  function automatic logic [POS_FIELD_W-1:0] pos_field(input logic [PTR_W-1:0] idx);
    logic [PTR_W+POS_FIELD_W-1:0] w;
    w = (PTR_W + POS_FIELD_W)'(idx);
    return w[POS_FIELD_W-1:0];
  endfunction

  function automatic logic [CNT_FIELD_W-1:0] cnt_field(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+CNT_FIELD_W-1:0] w;
    w = (CNT_W + CNT_FIELD_W)'(cnt);
    return w[CNT_FIELD_W-1:0];
  endfunction

endpackage

### sv/bdq_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/bdq_front.sv
`timescale 1ns / 1ps
// front end: accepts input transfers, decodes the op and queues commands
// depends on bdq_pkg

module bdq_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bdq_pkg::in_t     in_data,
  output bdq_pkg::cmd_ch_t cmd_ch,
  input  logic             cmd_take
);
  import bdq_pkg::*;

  cmd_t             q_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] fill_r, fill_nxt;
  cmd_t             dec_cmd;
  logic             push, pop;

  // decode
  always_comb begin
    dec_cmd.value = in_data.value;
    unique case (in_data.op)
      OP_PUSH_FRONT: dec_cmd.kind = K_PUSH_F;
      OP_PUSH_BACK:  dec_cmd.kind = K_PUSH_B;
      OP_POP_FRONT:  dec_cmd.kind = K_POP_F;
      OP_POP_BACK:   dec_cmd.kind = K_POP_B;
      OP_SEARCH:     dec_cmd.kind = K_SEARCH;
      OP_CLEAR:      dec_cmd.kind = K_CLEAR;
      default:       dec_cmd.kind = K_NOP;
    endcase
  end

  assign in_stall = (fill_r == CQ_CW'(CQ_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = cmd_take && cmd_ch.valid;

  assign cmd_ch.valid = (fill_r != '0);
  assign cmd_ch.cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + CQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + CQ_AW'(1) : rd_ptr_r;
    fill_nxt   = fill_r + CQ_CW'(push) - CQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

### sv/bdq_back.sv
`timescale 1ns / 1ps
// back end: ring pointers, slot ram, search walk and result register
// depends on bdq_pkg and bdq_ram

module bdq_back (
  input  logic             clk,
  input  logic             rst_n,
  input  bdq_pkg::cmd_ch_t cmd_ch,
  output logic             cmd_take,
  output logic             out_valid,
  input  logic             out_stall,
  output bdq_pkg::out_t    out_data
);
  import bdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SCAN = 3'b100
  } bstate_t;

  bstate_t            state_r, state_nxt;
  logic [PTR_W-1:0]   fp_r, fp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0]   idx_r, idx_nxt;
  cmd_t               cur_r, cur_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               wr_en, rd_en;
  logic [PTR_W-1:0]   wr_addr, rd_addr;
  logic [VALUE_W-1:0] wr_data, rd_data;

  logic               out_free, load_out;
  status_t            res_status;
  logic [VALUE_W-1:0] res_removed;
  logic [PTR_W-1:0]   res_pos;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    fp_nxt      = fp_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    cur_nxt     = cur_r;
    cmd_take    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = fp_r;
    wr_data     = cmd_ch.cmd.value;
    rd_en       = 1'b0;
    rd_addr     = fp_r;
    load_out    = 1'b0;
    res_status  = STAT_OK;
    res_removed = '0;
    res_pos     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_ch.valid && out_free) begin
          cmd_take = 1'b1;
          cur_nxt  = cmd_ch.cmd;
          unique case (cmd_ch.cmd.kind)
            K_PUSH_F: begin
              load_out = 1'b1;
              if (cnt_r == CNT_W'(DEPTH)) begin
                res_status = STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ring_dec(fp_r);
                fp_nxt  = ring_dec(fp_r);
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            K_PUSH_B: begin
              load_out = 1'b1;
              if (cnt_r == CNT_W'(DEPTH)) begin
                res_status = STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ring_add(fp_r, cnt_r);
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            K_POP_F, K_POP_B: begin
              if (cnt_r == '0) begin
                load_out   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = (cmd_ch.cmd.kind == K_POP_F) ? fp_r
                                                         : ring_add(fp_r, cnt_r - CNT_W'(1));
                state_nxt = S_READ;
              end
            end
            K_SEARCH: begin
              if (cnt_r == '0) begin
                load_out   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = fp_r;
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            K_CLEAR: begin
              load_out = 1'b1;
              cnt_nxt  = '0;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load_out    = 1'b1;
          res_removed = rd_data;
          cnt_nxt     = cnt_r - CNT_W'(1);
          if (cur_r.kind == K_POP_F) begin
            fp_nxt = ring_add(fp_r, CNT_W'(1));
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (rd_data == cur_r.value) begin
            load_out  = 1'b1;
            res_pos   = idx_r;
            state_nxt = S_IDLE;
          end else if (CNT_W'(idx_r) == cnt_r - CNT_W'(1)) begin
            load_out   = 1'b1;
            res_status = STAT_MISS;
            state_nxt  = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ring_add(fp_r, CNT_W'(idx_r) + CNT_W'(1));
            idx_nxt = idx_r + PTR_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt               = load_out || (out_valid_r && out_stall);
    out_data_nxt                = out_data_r;
    if (load_out) begin
      out_data_nxt.status         = res_status;
      out_data_nxt.removed_value  = res_removed;
      out_data_nxt.found_position = pos_field(res_pos);
      out_data_nxt.entry_count    = cnt_field(cnt_nxt);
      out_data_nxt.is_empty       = (cnt_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fp_r        <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fp_r        <= fp_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bdq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // never more entries than slots
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !load_out)
    else $error("result register overwritten while stalled");

  // the walk never passes the live entries
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CNT_W'(idx_r) < cnt_r))
    else $error("search index past entry count");

  // slot writes only come from pushes in the idle state
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_IDLE && !rd_en))
    else $error("slot write outside idle");

  // after a command is taken the state is one of the three legal one-hot states
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |=> (state_r == S_IDLE || state_r == S_READ || state_r == S_SCAN) &&
                 $onehot(state_r))
    else $error("bad state after command take");

endmodule

### sv/bounded_deque_with_search.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit values held in a ring of
// bdq_pkg::DEPTH slots, with push and pop at both ends, a search for the
// first match from the front, and clear. Every input transfer gives exactly
// one result transfer, in order. A decoding front end feeds a two-entry
// command queue; the back end owns the ring pointers, the slot ram (one
// write and one registered read port) and the result register. Pushes,
// clear and refused or empty cases load their result as the command is
// taken, pops wait for the ram read, and a search compares entries from
// the front, up to the entry count, as the walk reads one slot per cycle
// through the single read port while the result register is free. The
// back end works on one command at a time; the front keeps taking transfers
// while the queue has room. The slot store needs no clearing after reset.
// depends on bdq_pkg, bdq_front, bdq_back

module bounded_deque_with_search (
  input  logic          clk,
  input  logic          rst_n,
  // input channel
  input  logic          in_valid,
  output logic          in_stall,
  input  bdq_pkg::in_t  in_data,
  // result channel
  output logic          out_valid,
  input  logic          out_stall,
  output bdq_pkg::out_t out_data
);
  import bdq_pkg::*;

  // decoded commands from the front end to the back end
  cmd_ch_t cmd_ch;
  // back end takes the head command
  logic    cmd_take;

  // accept and decode input transfers
  bdq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cmd_ch   (cmd_ch),
    .cmd_take (cmd_take)
  );

  // execute commands against the ring and register results
  bdq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ch    (cmd_ch),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
